### src/radar_measurement_jacobian_core_assert.svh
// Assertion macros for the radar Jacobian core checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RADAR_MEASUREMENT_JACOBIAN_CORE_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_CORE_ASSERT_SVH

// Implication checked only outside reset
`define RMJ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked only outside reset
`define RMJ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Property checked at every edge, reset included
`define RMJ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

### src/rmj_pkg.sv
// Shared constants, word types and helpers for the radar Jacobian core.
// No dependencies.
package rmj_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int R2_W        = 2 * WORD_W;
    localparam int R3_W        = R2_W + WORD_W;
    localparam int NUM_W       = 128;
    localparam int QUO_W       = WORD_W;
    localparam int SQ_STAGES   = WORD_W;
    localparam int DIV_STAGES  = QUO_W + 1;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CFG_W       = 31;
    localparam int ADDR_W      = 2;
    localparam int APB_W       = 32;
    localparam logic [CFG_W-1:0] MIN_RANGE_RESET = CFG_W'(7);
    localparam logic [ADDR_W-1:0] MIN_RANGE_ADDR = ADDR_W'(0);

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
    } item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] range_by_px;
        logic signed [WORD_W-1:0] range_by_py;
        logic signed [WORD_W-1:0] bearing_by_px;
        logic signed [WORD_W-1:0] bearing_by_py;
        logic signed [WORD_W-1:0] rate_by_px;
        logic signed [WORD_W-1:0] rate_by_py;
        logic                     too_close;
        logic                     saturated;
    } result_t;

    // classified word between front and back
    typedef struct packed {
        logic [WORD_W-1:0] pxm;
        logic [WORD_W-1:0] pym;
        logic              pxn;
        logic              pyn;
        logic              dneg;
        logic              too_close;
        logic [R2_W-1:0]   r2;
        logic [R2_W-1:0]   dmag;
    } entry_t;

    function automatic logic [WORD_W-1:0] mag_of(input logic [WORD_W-1:0] raw);
        return raw[WORD_W-1] ? (~raw + WORD_W'(1)) : raw;
    endfunction

endpackage

### src/rmj_front.sv
// Front end: takes state vectors, forms magnitudes, r^2, cross term and the too-close flag.
// Depends on rmj_pkg.
module rmj_front
    import rmj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  item_t                item,
    input  logic [CFG_W-1:0]     min_range,
    input  logic [QUEUE_AW:0]    q_count,
    output logic                 q_push,
    output entry_t               q_entry
);

    localparam int PEND_W = QUEUE_AW + 2;

    logic v1_reg, v2_reg, v3_reg;
    logic [WORD_W-1:0] pxm1_reg, pym1_reg, vxm1_reg, vym1_reg;
    logic pxn1_reg, pyn1_reg, vxn1_reg, vyn1_reg;
    logic [R2_W-1:0] pxx2_reg, pyy2_reg, a2_reg, b2_reg;
    logic an2_reg, bn2_reg;
    logic [WORD_W-1:0] pxm2_reg, pym2_reg, pxm3_reg, pym3_reg;
    logic pxn2_reg, pyn2_reg, pxn3_reg, pyn3_reg;
    logic [R2_W-1:0] r2_3_reg;
    logic signed [R2_W+1:0] diff3_reg;
    logic signed [R2_W+1:0] sa, sb, dabs;
    logic [PEND_W-1:0] pending;
    logic [R2_W-1:0] thr;
    logic accept;

    // credit check: queue entries plus words still in the front
    assign pending = PEND_W'(q_count) + PEND_W'(v1_reg) + PEND_W'(v2_reg) + PEND_W'(v3_reg);
    assign full    = pending >= PEND_W'(QUEUE_DEPTH);
    assign accept  = push && !full;

    // signed cross products for vx*py - vy*px
    always_comb
    begin
        sa = an2_reg ? -$signed({2'b00, a2_reg}) : $signed({2'b00, a2_reg});
        sb = bn2_reg ? -$signed({2'b00, b2_reg}) : $signed({2'b00, b2_reg});
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        pxm1_reg <= mag_of(item.pos_x);
        pym1_reg <= mag_of(item.pos_y);
        vxm1_reg <= mag_of(item.vel_x);
        vym1_reg <= mag_of(item.vel_y);
        pxn1_reg <= item.pos_x[WORD_W-1];
        pyn1_reg <= item.pos_y[WORD_W-1];
        vxn1_reg <= item.vel_x[WORD_W-1];
        vyn1_reg <= item.vel_y[WORD_W-1];

        pxx2_reg <= pxm1_reg * pxm1_reg;
        pyy2_reg <= pym1_reg * pym1_reg;
        a2_reg   <= vxm1_reg * pym1_reg;
        b2_reg   <= vym1_reg * pxm1_reg;
        an2_reg  <= vxn1_reg ^ pyn1_reg;
        bn2_reg  <= vyn1_reg ^ pxn1_reg;
        pxm2_reg <= pxm1_reg;
        pym2_reg <= pym1_reg;
        pxn2_reg <= pxn1_reg;
        pyn2_reg <= pyn1_reg;

        r2_3_reg  <= pxx2_reg + pyy2_reg;
        diff3_reg <= sa - sb;
        pxm3_reg  <= pxm2_reg;
        pym3_reg  <= pym2_reg;
        pxn3_reg  <= pxn2_reg;
        pyn3_reg  <= pyn2_reg;
    end

    // classify and hand to the queue
    assign thr  = R2_W'(min_range) << FRAC_BITS;
    assign dabs = diff3_reg[R2_W+1] ? -diff3_reg : diff3_reg;

    always_comb
    begin
        q_push            = v3_reg;
        q_entry.pxm       = pxm3_reg;
        q_entry.pym       = pym3_reg;
        q_entry.pxn       = pxn3_reg;
        q_entry.pyn       = pyn3_reg;
        q_entry.dneg      = diff3_reg[R2_W+1];
        q_entry.too_close = (r2_3_reg == '0) || (r2_3_reg < thr);
        q_entry.r2        = r2_3_reg;
        q_entry.dmag      = dabs[R2_W-1:0];
    end

endmodule

### src/rmj_queue.sv
// Short queue that decouples the front end from the back end.
// Depends on rmj_pkg.
module rmj_queue
    import rmj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  entry_t            wdata,
    input  logic              rd,
    output entry_t            rdata,
    output logic              q_empty,
    output logic [QUEUE_AW:0] count
);

    entry_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign rdata   = mem_reg[rptr_reg];
    assign q_empty = (count_reg == '0);
    assign count   = count_reg;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
                wptr_reg <= wptr_reg + QUEUE_AW'(1);
            if (rd)
                rptr_reg <= rptr_reg + QUEUE_AW'(1);
            if (wr && !rd)
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            else if (rd && !wr)
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

### src/rmj_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on rmj_pkg.
module rmj_sqrt
    import rmj_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [R2_W-1:0]   v_in,
    output logic [WORD_W-1:0] root
);

    logic [R2_W-1:0] rem_reg [SQ_STAGES];
    logic [R2_W-1:0] res_reg [SQ_STAGES];
    logic [R2_W-1:0] rem_in  [SQ_STAGES];
    logic [R2_W-1:0] res_in  [SQ_STAGES];
    logic [R2_W-1:0] rem_n   [SQ_STAGES];
    logic [R2_W-1:0] res_n   [SQ_STAGES];

    // one digit-pair per stage, bit weight fixed by stage position
    always_comb
    begin
        logic [R2_W-1:0] bitw;
        logic [R2_W-1:0] trial;
        rem_in[0] = v_in;
        res_in[0] = '0;
        for (int i = 1; i < SQ_STAGES; i++)
        begin
            rem_in[i] = rem_reg[i-1];
            res_in[i] = res_reg[i-1];
        end
        for (int i = 0; i < SQ_STAGES; i++)
        begin
            bitw  = R2_W'(1) << (R2_W - 2 - 2 * i);
            trial = res_in[i] + bitw;
            if (rem_in[i] >= trial)
            begin
                rem_n[i] = rem_in[i] - trial;
                res_n[i] = (res_in[i] >> 1) + bitw;
            end
            else
            begin
                rem_n[i] = rem_in[i];
                res_n[i] = res_in[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQ_STAGES; i++)
            begin
                rem_reg[i] <= rem_n[i];
                res_reg[i] <= res_n[i];
            end
        end
    end

    assign root = res_reg[SQ_STAGES-1][WORD_W-1:0];

endmodule

### src/rmj_div.sv
// Pipelined restoring divider, quotient limited to 2^32, one bit per stage.
// Depends on rmj_pkg.
module rmj_div
    import rmj_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [R3_W-1:0]  den,
    output logic [QUO_W:0]   quo
);

    logic [R3_W-1:0]  den_reg [DIV_STAGES];
    logic [R3_W-1:0]  rem_reg [DIV_STAGES];
    logic [QUO_W-1:0] lq_reg  [DIV_STAGES];
    logic             ovf_reg [DIV_STAGES];
    logic [R3_W-1:0]  rem_n   [DIV_STAGES];
    logic [QUO_W-1:0] lq_n    [DIV_STAGES];

    // quotient bits: shift one numerator bit in, compare, subtract
    always_comb
    begin
        logic [R3_W:0] rsh;
        logic [R3_W:0] dif;
        rem_n[0] = num[NUM_W-1:QUO_W];
        lq_n[0]  = num[QUO_W-1:0];
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            rsh = {rem_reg[i-1], lq_reg[i-1][QUO_W-1]};
            dif = rsh - {1'b0, den_reg[i-1]};
            if (rsh >= {1'b0, den_reg[i-1]})
            begin
                rem_n[i] = dif[R3_W-1:0];
                lq_n[i]  = {lq_reg[i-1][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_n[i] = rsh[R3_W-1:0];
                lq_n[i]  = {lq_reg[i-1][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            ovf_reg[0] <= num >= {den, QUO_W'(0)};
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                rem_reg[i] <= rem_n[i];
                lq_reg[i]  <= lq_n[i];
            end
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    assign quo = ovf_reg[DIV_STAGES-1] ? {1'b1, QUO_W'(0)}
                                       : {1'b0, lq_reg[DIV_STAGES-1]};

endmodule

### src/rmj_back.sv
// Back end: square root, r^3 and numerator products, six dividers, clipping, result register.
// Depends on rmj_pkg, rmj_sqrt, rmj_div.
module rmj_back
    import rmj_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  entry_t  q_entry,
    output logic    q_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam int N_ENT = 6;
    localparam int HW    = WORD_W;

    typedef struct packed {
        logic [N_ENT-1:0] neg;
        logic             too_close;
    } side_t;

    logic adv;
    logic sq_vld_reg [SQ_STAGES];
    entry_t sq_ent_reg [SQ_STAGES];
    logic [WORD_W-1:0] root;

    logic m1_vld_reg, m2_vld_reg, out_valid_reg;
    entry_t m1_ent_reg, m2_ent_reg;
    logic [WORD_W-1:0] m1_r_reg, m2_r_reg;
    logic [R2_W-1:0] p_r3lo_reg, p_r3hi_reg, p_ylo_reg, p_yhi_reg, p_xlo_reg, p_xhi_reg;
    logic [R3_W-1:0] r3_reg, prod_y_reg, prod_x_reg;

    logic  dv_vld_reg  [DIV_STAGES];
    side_t dv_side_reg [DIV_STAGES];
    side_t side_in;

    logic [NUM_W-1:0] num_arr [N_ENT];
    logic [R3_W-1:0]  den_arr [N_ENT];
    logic [QUO_W:0]   quo_arr [N_ENT];
    logic [WORD_W:0]  clip_arr [N_ENT];
    result_t result_reg, result_next;

    function automatic logic [WORD_W:0] clip_entry(input logic neg, input logic [QUO_W:0] mag);
        logic [QUO_W:0] negv;
        negv = ~mag + (QUO_W+1)'(1);
        if (mag == '0)
            return '0;
        if (neg)
        begin
            if (mag > {1'b0, 1'b1, (QUO_W-1)'(0)})
                return {1'b1, 1'b1, (WORD_W-1)'(0)};
            return {1'b0, negv[WORD_W-1:0]};
        end
        if (mag > {2'b00, {(QUO_W-1){1'b1}}})
            return {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
        return {1'b0, mag[WORD_W-1:0]};
    endfunction

    // whole back end moves together while the result register can take a word
    assign adv   = !out_valid_reg || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !out_valid_reg;
    assign result = result_reg;

    rmj_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .v_in (q_entry.r2),
        .root (root)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_STAGES; i++)
                sq_vld_reg[i] <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
                dv_vld_reg[i] <= 1'b0;
            m1_vld_reg    <= 1'b0;
            m2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= !q_empty;
            for (int i = 1; i < SQ_STAGES; i++)
                sq_vld_reg[i] <= sq_vld_reg[i-1];
            m1_vld_reg    <= sq_vld_reg[SQ_STAGES-1];
            m2_vld_reg    <= m1_vld_reg;
            dv_vld_reg[0] <= m2_vld_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                dv_vld_reg[i] <= dv_vld_reg[i-1];
            out_valid_reg <= dv_vld_reg[DIV_STAGES-1];
        end
    end

    // sign of each entry
    always_comb
    begin
        side_in.neg[0]    = m2_ent_reg.pxn;
        side_in.neg[1]    = m2_ent_reg.pyn;
        side_in.neg[2]    = !m2_ent_reg.pyn;
        side_in.neg[3]    = m2_ent_reg.pxn;
        side_in.neg[4]    = m2_ent_reg.dneg != m2_ent_reg.pyn;
        side_in.neg[5]    = (!m2_ent_reg.dneg) != m2_ent_reg.pxn;
        side_in.too_close = m2_ent_reg.too_close;
    end

    // payload: side line, partial products, product sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_ent_reg[0] <= q_entry;
            for (int i = 1; i < SQ_STAGES; i++)
                sq_ent_reg[i] <= sq_ent_reg[i-1];

            m1_ent_reg <= sq_ent_reg[SQ_STAGES-1];
            m1_r_reg   <= root;
            p_r3lo_reg <= sq_ent_reg[SQ_STAGES-1].r2[HW-1:0] * root;
            p_r3hi_reg <= sq_ent_reg[SQ_STAGES-1].r2[R2_W-1:HW] * root;
            p_ylo_reg  <= sq_ent_reg[SQ_STAGES-1].dmag[HW-1:0] * sq_ent_reg[SQ_STAGES-1].pym;
            p_yhi_reg  <= sq_ent_reg[SQ_STAGES-1].dmag[R2_W-1:HW] * sq_ent_reg[SQ_STAGES-1].pym;
            p_xlo_reg  <= sq_ent_reg[SQ_STAGES-1].dmag[HW-1:0] * sq_ent_reg[SQ_STAGES-1].pxm;
            p_xhi_reg  <= sq_ent_reg[SQ_STAGES-1].dmag[R2_W-1:HW] * sq_ent_reg[SQ_STAGES-1].pxm;

            m2_ent_reg <= m1_ent_reg;
            m2_r_reg   <= m1_r_reg;
            r3_reg     <= (R3_W'(p_r3hi_reg) << HW) + R3_W'(p_r3lo_reg);
            prod_y_reg <= (R3_W'(p_yhi_reg) << HW) + R3_W'(p_ylo_reg);
            prod_x_reg <= (R3_W'(p_xhi_reg) << HW) + R3_W'(p_xlo_reg);

            dv_side_reg[0] <= side_in;
            for (int i = 1; i < DIV_STAGES; i++)
                dv_side_reg[i] <= dv_side_reg[i-1];

            result_reg <= result_next;
        end
    end

    // numerators scaled to the output format, and divisors
    always_comb
    begin
        num_arr[0] = NUM_W'(m2_ent_reg.pxm) << FRAC_BITS;
        num_arr[1] = NUM_W'(m2_ent_reg.pym) << FRAC_BITS;
        num_arr[2] = NUM_W'(m2_ent_reg.pym) << (2 * FRAC_BITS);
        num_arr[3] = NUM_W'(m2_ent_reg.pxm) << (2 * FRAC_BITS);
        num_arr[4] = NUM_W'(prod_y_reg) << FRAC_BITS;
        num_arr[5] = NUM_W'(prod_x_reg) << FRAC_BITS;
        den_arr[0] = R3_W'(m2_r_reg);
        den_arr[1] = R3_W'(m2_r_reg);
        den_arr[2] = R3_W'(m2_ent_reg.r2);
        den_arr[3] = R3_W'(m2_ent_reg.r2);
        den_arr[4] = r3_reg;
        den_arr[5] = r3_reg;
    end

    for (genvar k = 0; k < N_ENT; k++)
    begin : g_div
        rmj_div u_div (
            .clk (clk),
            .en  (adv),
            .num (num_arr[k]),
            .den (den_arr[k]),
            .quo (quo_arr[k])
        );
    end

    // clip to Q format and assemble the result word
    always_comb
    begin
        for (int k = 0; k < N_ENT; k++)
            clip_arr[k] = clip_entry(dv_side_reg[DIV_STAGES-1].neg[k], quo_arr[k]);
        result_next.range_by_px   = clip_arr[0][WORD_W-1:0];
        result_next.range_by_py   = clip_arr[1][WORD_W-1:0];
        result_next.bearing_by_px = clip_arr[2][WORD_W-1:0];
        result_next.bearing_by_py = clip_arr[3][WORD_W-1:0];
        result_next.rate_by_px    = clip_arr[4][WORD_W-1:0];
        result_next.rate_by_py    = clip_arr[5][WORD_W-1:0];
        result_next.too_close     = 1'b0;
        result_next.saturated     = clip_arr[0][WORD_W] | clip_arr[1][WORD_W] |
                                    clip_arr[2][WORD_W] | clip_arr[3][WORD_W] |
                                    clip_arr[4][WORD_W] | clip_arr[5][WORD_W];
        if (dv_side_reg[DIV_STAGES-1].too_close)
        begin
            result_next           = '0;
            result_next.too_close = 1'b1;
        end
    end

endmodule

### src/radar_measurement_jacobian_core.sv
// Radar measurement Jacobian core: px/r, py/r, -py/r^2, px/r^2 and range-rate terms.
// Throughput: one word per cycle unless held by full or an untaken result; set by
// the square-root and divider pipelines, which resolve one result bit per stage.
// Reset: asynchronous, clears all valid state; min_range_squared returns to 7.
// Depends on rmj_pkg, rmj_front, rmj_queue, rmj_back.
module radar_measurement_jacobian_core
    import rmj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  item_t             item,
    output logic              empty,
    input  logic              pop,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    logic [CFG_W-1:0] min_range_reg;
    logic q_push, q_pop, q_empty;
    entry_t q_wdata, q_rdata;
    logic [QUEUE_AW:0] q_count;

    // config register at byte address 0
    assign pready = 1'b1;
    assign prdata = {1'b0, min_range_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_range_reg <= MIN_RANGE_RESET;
        else if (psel && penable && pwrite && (paddr == MIN_RANGE_ADDR))
            min_range_reg <= pwdata[CFG_W-1:0];
    end

    rmj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .min_range (min_range_reg),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_entry   (q_wdata)
    );

    rmj_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wdata   (q_wdata),
        .rd      (q_pop),
        .rdata   (q_rdata),
        .q_empty (q_empty),
        .count   (q_count)
    );

    rmj_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (q_rdata),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

### src/rmj_checker.sv
// Port-level checker for the radar Jacobian core, bound to the top level.
// Depends on rmj_pkg and radar_measurement_jacobian_core_assert.svh.
`include "radar_measurement_jacobian_core_assert.svh"

module rmj_checker
    import rmj_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    logic any_zero_entry;
    logic clipped_seen;
    logic reset_quiet;
    logic close_word;
    logic close_ok;
    logic sat_word;

    assign any_zero_entry = (result.range_by_px == '0) && (result.range_by_py == '0) &&
                            (result.bearing_by_px == '0) && (result.bearing_by_py == '0) &&
                            (result.rate_by_px == '0) && (result.rate_by_py == '0);

    assign clipped_seen =
        (result.range_by_px == 32'h7FFF_FFFF) || (result.range_by_px == 32'h8000_0000) ||
        (result.range_by_py == 32'h7FFF_FFFF) || (result.range_by_py == 32'h8000_0000) ||
        (result.bearing_by_px == 32'h7FFF_FFFF) || (result.bearing_by_px == 32'h8000_0000) ||
        (result.bearing_by_py == 32'h7FFF_FFFF) || (result.bearing_by_py == 32'h8000_0000) ||
        (result.rate_by_px == 32'h7FFF_FFFF) || (result.rate_by_px == 32'h8000_0000) ||
        (result.rate_by_py == 32'h7FFF_FFFF) || (result.rate_by_py == 32'h8000_0000);

    // empty may still be unknown before the first clocked reset
    assign reset_quiet = (rst_n !== 1'b0) || (empty !== 1'b0);
    assign close_word  = !empty && result.too_close;
    assign close_ok    = any_zero_entry && !result.saturated;
    assign sat_word    = !empty && result.saturated;

    // no result word during reset
    `RMJ_ASSERT_ALWAYS(a_empty_in_reset, reset_quiet, "result shown during reset")

    // too-close word carries zero entries and no clip flag
    `RMJ_ASSERT_IMPL(a_close_zero, close_word, close_ok, "too-close word not cleared")

    // clip flag only with an entry at a range limit
    `RMJ_ASSERT_IMPL(a_sat_limit, sat_word, clipped_seen, "saturated without clipped entry")

    // a waiting word holds until taken
    `RMJ_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "waiting word changed")

endmodule

bind radar_measurement_jacobian_core rmj_checker u_checker (.*);

### tb/radar_measurement_jacobian_core_tb.sv
// Testbench for radar_measurement_jacobian_core: random and directed state vectors,
// a bit-exact Jacobian predictor in a small scoreboard class. Depends on rmj_pkg.
`timescale 1ns / 1ps

module radar_measurement_jacobian_core_tb;
    import rmj_pkg::*;

    localparam int LATENCY     = 71;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    item_t             item = '0;
    logic              empty;
    logic              pop = 1'b0;
    result_t           result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0]  pwdata = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    int  cycles = 0;
    bit  hold_pop = 1'b0;

    radar_measurement_jacobian_core dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Jacobian predictor and expected-word store
    class jacobian_board;
        logic [CFG_W-1:0] min_range;
        result_t          pending[$];
        int               errors;

        function new();
            min_range = MIN_RANGE_RESET;
            errors = 0;
        endfunction

        static function logic [31:0] mag32(logic [31:0] v);
            return v[31] ? (~v + 32'd1) : v;
        endfunction

        // truncated quotient capped at 2^32
        static function logic [32:0] quot(logic [127:0] num, logic [127:0] den);
            logic [127:0] q;
            q = num / den;
            return (q > 128'h1_0000_0000) ? 33'h1_0000_0000 : q[32:0];
        endfunction

        static function logic [31:0] clip(bit neg, logic [32:0] m, ref bit sat);
            if (m == 0) return 32'd0;
            if (neg)
            begin
                if (m > 33'h0_8000_0000)
                begin
                    sat = 1'b1;
                    m = 33'h0_8000_0000;
                end
                return ~m[31:0] + 32'd1;
            end
            if (m > 33'h0_7FFF_FFFF)
            begin
                sat = 1'b1;
                m = 33'h0_7FFF_FFFF;
            end
            return m[31:0];
        endfunction

        function result_t jacobian(item_t it);
            result_t       res;
            bit            pxn, pyn, vxn, vyn, dneg, sat;
            logic [63:0]   px, py, vx, vy, r2, r, a, b, dmag;
            logic [127:0]  r3;
            logic [95:0]   thr;
            res = '0;
            sat = 1'b0;
            pxn = it.pos_x[31];
            pyn = it.pos_y[31];
            vxn = it.vel_x[31];
            vyn = it.vel_y[31];
            px = 64'(mag32(it.pos_x));
            py = 64'(mag32(it.pos_y));
            vx = 64'(mag32(it.vel_x));
            vy = 64'(mag32(it.vel_y));
            r2 = px * px + py * py;
            thr = {65'd0, min_range} << FRAC_BITS;
            if (r2 == 0 || {32'd0, r2} < thr)
            begin
                res.too_close = 1'b1;
                return res;
            end
            r = 0;
            for (int i = 31; i >= 0; i--)
            begin
                if ((r | (64'd1 << i)) * (r | (64'd1 << i)) <= r2) r |= 64'd1 << i;
            end
            r3 = 128'(r2) * 128'(r);
            a = vx * py;
            b = vy * px;
            if (vxn != pyn) a = -a;
            if (vyn != pxn) b = -b;
            if ($signed(a) >= $signed(b))
            begin
                dneg = 1'b0;
                dmag = a - b;
            end
            else
            begin
                dneg = 1'b1;
                dmag = b - a;
            end
            res.range_by_px   = clip(pxn, quot({64'd0, px} << FRAC_BITS, 128'(r)), sat);
            res.range_by_py   = clip(pyn, quot({64'd0, py} << FRAC_BITS, 128'(r)), sat);
            res.bearing_by_px = clip(!pyn, quot({64'd0, py} << (2 * FRAC_BITS), 128'(r2)), sat);
            res.bearing_by_py = clip(pxn, quot({64'd0, px} << (2 * FRAC_BITS), 128'(r2)), sat);
            res.rate_by_px = clip(dneg != pyn,
                quot(({64'd0, dmag} * {64'd0, py}) << FRAC_BITS, r3), sat);
            res.rate_by_py = clip((!dneg) != pxn,
                quot(({64'd0, dmag} * {64'd0, px}) << FRAC_BITS, r3), sat);
            res.saturated = sat;
            return res;
        endfunction

        function void note_item(item_t it);
            pending.push_back(jacobian(it));
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    jacobian_board board = new();

    // APB write: setup then access
    task automatic write_min_range(logic [CFG_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= MIN_RANGE_ADDR;
        pwdata <= {1'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.min_range = val;
    endtask

    // push stays high across back-to-back words
    task automatic send_word(item_t it, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_item(it);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            3: return {($urandom_range(0, 1) != 0) ? 4'hF : 4'h0, 28'h0}
                      ^ $urandom_range(0, 255);
            default: return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.pos_x = rand_coord();
        it.pos_y = rand_coord();
        it.vel_x = $urandom;
        it.vel_y = rand_coord();
        return it;
    endfunction

    // result side: random pop gaps, plus a long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap != 0 || hold_pop)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_pop) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            board.check_word(result);
        end
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        item_t it;
        logic [31:0] ext[4];
        logic [CFG_W-1:0] thr_set[5];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        thr_set = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd100, 31'd7};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_min_range(31'd0);

        // directed: zero range with zero threshold, field extremes
        send_word('{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_word('{ext[i], ext[j], ext[j], ext[i]}, 1'b0);
        send_word('{32'h1, 32'h0, 32'h0, 32'h0}, 1'b0);
        send_word('{32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0}, 1'b0);
        send_word('{32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000, 32'h0002_0000}, 1'b0);
        drain();
        write_min_range(31'd7);
        // small positions with the threshold back at 7
        send_word('{32'h0002_0000, 32'h0001_0000, 32'h1, 32'h1}, 1'b0);
        send_word('{32'h0002_0000, 32'h0001_8000, 32'h1, 32'h1}, 1'b0);
        send_word('{32'h0, 32'h0000_8000, 32'h1, 32'h1}, 1'b0);
        drain();

        // back-to-back with receiver held off so the queue fills
        hold_pop = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_pop = 1'b0;
            end
            for (int n = 0; n < 150; n++) send_word(rand_item(), 1'b1);
        join
        drain();

        // random phases across thresholds
        for (int p = 0; p < 5; p++)
        begin
            write_min_range(thr_set[p]);
            for (int n = 0; n < 300; n++)
            begin
                it = rand_item();
                send_word(it, $urandom_range(0, 3) == 0);
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/rmj_pkg.sv
src/rmj_front.sv
src/rmj_queue.sv
src/rmj_sqrt.sv
src/rmj_div.sv
src/rmj_back.sv
src/radar_measurement_jacobian_core.sv
src/rmj_checker.sv
tb/radar_measurement_jacobian_core_tb.sv
